// ===== src/sample_statistics_with_bins_macros.svh =====
// ----------------------------------------------------------------------------
// Sample statistics with bins: assertion macros
// Concurrent assertion helpers shared by the RTL of the block. They expand
// to nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef SAMPLE_STATISTICS_WITH_BINS_MACROS_SVH
`define SAMPLE_STATISTICS_WITH_BINS_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked on every rising clock edge outside reset.
`define SSB_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication, checked on every rising clock edge outside reset.
`define SSB_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define SSB_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg)
`define SSB_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

// ===== src/ssb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sample statistics with bins: package
// Widths, register codes, reset values and sequencing codes of the block.
// ----------------------------------------------------------------------------
package ssb_pkg;

   // Default sizing of the sample store.
   localparam int unsigned DEF_MAX_SAMPLES = 128;
   localparam int unsigned DEF_SAMPLE_BITS = 16;

   // Field widths of the transfers.
   localparam int unsigned VALUE_W     = 16;
   localparam int unsigned COUNT_OUT_W = 8;
   localparam int unsigned PCT_W       = 14;
   localparam int unsigned STATUS_W    = 2;
   localparam int unsigned NUM_BINS    = 5;
   localparam int unsigned NUM_PCT     = 6;

   // Register port.
   localparam int unsigned CSR_ADDR_W = 4;
   localparam int unsigned CSR_DATA_W = 32;

   // Shares are given in hundredths of a percent.
   localparam logic [PCT_W-1:0] PCT_SCALE = 14'd10000;

   // Reset values of the limits (Q8.8: 18.5, 20.0, 25.0, 30.0).
   localparam logic [VALUE_W-1:0] LIMIT_UNDER_RST = 16'd4736;
   localparam logic [VALUE_W-1:0] LIMIT_LOW_RST   = 16'd5120;
   localparam logic [VALUE_W-1:0] LIMIT_MID_RST   = 16'd6400;
   localparam logic [VALUE_W-1:0] LIMIT_HIGH_RST  = 16'd7680;

   // Register indexes on the configuration port.
   typedef enum logic [1:0] {
      REG_LIMIT_UNDER = 2'd0,
      REG_LIMIT_LOW   = 2'd1,
      REG_LIMIT_MID   = 2'd2,
      REG_LIMIT_HIGH  = 2'd3
   } reg_index_type;

   // Result status codes.
   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK       = 2'd0,
      STATUS_SINGLE   = 2'd1,
      STATUS_OVERFLOW = 2'd2
   } status_type;

   // Divisions done by the shared divider, in order.
   typedef enum logic [2:0] {
      JOB_MEAN  = 3'd0,
      JOB_VAR   = 3'd1,
      JOB_ABOVE = 3'd2,
      JOB_UNDER = 3'd3,
      JOB_LOW   = 3'd4,
      JOB_MID   = 3'd5,
      JOB_HIGH  = 3'd6,
      JOB_TOP   = 3'd7
   } job_type;

endpackage

// ===== src/ssb_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sample statistics with bins: generic RAM
// Single write port, single read port, read data registered.
// ----------------------------------------------------------------------------
module ssb_ram
   import ssb_pkg::*;
#(
   parameter int unsigned WIDTH = VALUE_W,
   parameter int unsigned DEPTH = DEF_MAX_SAMPLES,
   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ===== src/sample_statistics_with_bins.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sample statistics with bins
// Samples are taken one per cycle while the block is collecting, one
// transfer each, and kept in a sample RAM while running sums and five bin
// counters are updated. The transfer marked last closes the set and starts
// the final pass: the stored samples are read back once to count those
// above the mean, n times the square sum is formed by a shift-add
// multiplier over the CNT_W bits of n, eight quotients come from one shared
// restoring divider on DW-bit operands and the standard deviation from a
// digit-by-digit square root, where CNT_W = clog2(MAX_SAMPLES + 1) and DW
// is 2 * min(SAMPLE_BITS, 16) + 2 * CNT_W rounded up to even (48 with the
// defaults). While a set is being finished no sample is taken, and finishing
// waits longer while an earlier result is still unclaimed. The result
// waits in an output register, so the next set loads while it is unclaimed.
// ----------------------------------------------------------------------------
`include "sample_statistics_with_bins_macros.svh"

module sample_statistics_with_bins
   import ssb_pkg::*;
#(
   parameter int unsigned MAX_SAMPLES = DEF_MAX_SAMPLES,
   parameter int unsigned SAMPLE_BITS = DEF_SAMPLE_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   // Sample channel.
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [VALUE_W-1:0]    req_sample_value,
   input  logic                  req_last_sample,
   // Result channel.
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [COUNT_OUT_W-1:0] rsp_sample_count,
   output logic [VALUE_W-1:0]    rsp_mean_value,
   output logic [VALUE_W-1:0]    rsp_std_dev,
   output logic [PCT_W-1:0]      rsp_pct_above_mean,
   output logic [PCT_W-1:0]      rsp_pct_bin_under,
   output logic [PCT_W-1:0]      rsp_pct_bin_low,
   output logic [PCT_W-1:0]      rsp_pct_bin_mid,
   output logic [PCT_W-1:0]      rsp_pct_bin_high,
   output logic [PCT_W-1:0]      rsp_pct_bin_top,
   output logic [STATUS_W-1:0]   rsp_status,
   // Configuration port.
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int unsigned XW     = (SAMPLE_BITS < VALUE_W) ? SAMPLE_BITS : VALUE_W;
   localparam int unsigned CNT_W  = $clog2(MAX_SAMPLES + 1);
   localparam int unsigned AW     = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
   localparam int unsigned SUM_W  = XW + CNT_W;
   localparam int unsigned SQ_W   = 2 * XW + CNT_W;
   localparam int unsigned NUM_W  = SQ_W + CNT_W;
   localparam int unsigned DW     = NUM_W + (NUM_W % 2);
   localparam int unsigned RT_W   = DW / 2;
   localparam int unsigned STEP_W = $clog2(DW + 1);

   typedef enum logic [5:0] {
      S_COLLECT = 6'b000001,
      S_SCAN    = 6'b000010,
      S_MUL     = 6'b000100,
      S_DIV     = 6'b001000,
      S_SQRT    = 6'b010000,
      S_LOAD    = 6'b100000
   } state_type;

   // Configuration registers.
   logic [VALUE_W-1:0] lim_under_ff, lim_low_ff, lim_mid_ff, lim_high_ff;
   logic               csr_wr;
   reg_index_type      csr_idx;

   // Set state.
   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   kept_ff, kept_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [SQ_W-1:0]    sq_ff, sq_in;
   logic [CNT_W-1:0]   bin_ff [NUM_BINS];
   logic [CNT_W-1:0]   bin_in [NUM_BINS];
   logic               ovf_ff, ovf_in;

   // Scan pass.
   logic [CNT_W-1:0]   scan_ff, scan_in;
   logic               rd_pend_ff, rd_pend_in;
   logic [CNT_W-1:0]   above_ff, above_in;
   logic [NUM_W-1:0]   sqr_ff, sqr_in;

   // Shift-add multiplier, divider and square root.
   logic [STEP_W-1:0]  step_ff, step_in;
   logic [NUM_W-1:0]   mul_acc_ff, mul_acc_in;
   logic [NUM_W-1:0]   mul_cand_ff, mul_cand_in;
   logic [CNT_W-1:0]   mul_ier_ff, mul_ier_in;
   job_type            job_ff, job_in;
   logic               div_busy_ff, div_busy_in;
   logic [DW:0]        div_rem_ff, div_rem_in;
   logic [DW-1:0]      div_quo_ff, div_quo_in;
   logic [DW-1:0]      div_den_ff, div_den_in;
   logic [VALUE_W-1:0] mean_ff, mean_in;
   logic [DW-1:0]      var_ff, var_in;
   logic [PCT_W-1:0]   pct_ff [NUM_PCT];
   logic [PCT_W-1:0]   pct_in [NUM_PCT];
   logic [DW-1:0]      sq_v_ff, sq_v_in;
   logic [DW-1:0]      sq_root_ff, sq_root_in;
   logic [DW-1:0]      sq_bit_ff, sq_bit_in;

   // Output register.
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [COUNT_OUT_W-1:0] rsp_count_ff, rsp_count_in;
   logic [VALUE_W-1:0]     rsp_mean_ff, rsp_mean_in;
   logic [VALUE_W-1:0]     rsp_sd_ff, rsp_sd_in;
   logic [PCT_W-1:0]       rsp_pct_ff [NUM_PCT];
   logic [PCT_W-1:0]       rsp_pct_in [NUM_PCT];
   logic [STATUS_W-1:0]    rsp_status_ff, rsp_status_in;

   // Datapath helpers.
   logic [XW-1:0]      x_val;
   logic [VALUE_W-1:0] x_ext;
   logic [2*XW-1:0]    x_sq;
   logic [NUM_BINS-1:0] bin_hit;
   logic               ram_wr_en;
   logic [AW-1:0]      ram_rd_addr;
   logic [XW-1:0]      ram_rd_data;
   logic [SUM_W-1:0]   scan_prod;
   logic [NUM_W-1:0]   num_val;
   logic [DW-1:0]      nn_val;
   logic [CNT_W-1:0]   share_cnt;
   logic [DW-1:0]      job_dividend;
   logic [DW-1:0]      job_divisor;
   logic [DW:0]        div_trial;
   logic               div_ge;
   logic [DW:0]        div_rem_nx;
   logic [DW-1:0]      div_quo_nx;
   logic [2:0]         pct_idx;
   logic [DW:0]        sq_trial;
   logic               sq_ge;
   logic [CNT_W+COUNT_OUT_W-1:0] n_wide;

   // Register port: always ready, writes land when the access phase completes.
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;
   assign csr_idx    = reg_index_type'(csr_paddr[CSR_ADDR_W-1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         lim_under_ff <= LIMIT_UNDER_RST;
         lim_low_ff   <= LIMIT_LOW_RST;
         lim_mid_ff   <= LIMIT_MID_RST;
         lim_high_ff  <= LIMIT_HIGH_RST;
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_LIMIT_UNDER: lim_under_ff <= csr_pwdata[VALUE_W-1:0];
            REG_LIMIT_LOW:   lim_low_ff   <= csr_pwdata[VALUE_W-1:0];
            REG_LIMIT_MID:   lim_mid_ff   <= csr_pwdata[VALUE_W-1:0];
            REG_LIMIT_HIGH:  lim_high_ff  <= csr_pwdata[VALUE_W-1:0];
            default: ;
         endcase
      end
   end

   // Register read data.
   always_comb begin
      unique case (csr_idx)
         REG_LIMIT_UNDER: csr_prdata = CSR_DATA_W'(lim_under_ff);
         REG_LIMIT_LOW:   csr_prdata = CSR_DATA_W'(lim_low_ff);
         REG_LIMIT_MID:   csr_prdata = CSR_DATA_W'(lim_mid_ff);
         REG_LIMIT_HIGH:  csr_prdata = CSR_DATA_W'(lim_high_ff);
         default:         csr_prdata = '0;
      endcase
   end

   // Incoming sample, its square and its bin tests.
   assign x_val = req_sample_value[XW-1:0];
   assign x_ext = VALUE_W'(x_val);
   assign x_sq  = (2*XW)'(x_val) * (2*XW)'(x_val);

   assign bin_hit[0] = x_ext < lim_under_ff;
   assign bin_hit[1] = (x_ext >= lim_under_ff) && (x_ext < lim_low_ff);
   assign bin_hit[2] = (x_ext >= lim_low_ff) && (x_ext < lim_mid_ff);
   assign bin_hit[3] = (x_ext >= lim_mid_ff) && (x_ext < lim_high_ff);
   assign bin_hit[4] = x_ext >= lim_high_ff;

   assign req_ready = (state_ff == S_COLLECT);

   // Sample store.
   ssb_ram #(
      .WIDTH (XW),
      .DEPTH (MAX_SAMPLES)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (kept_ff[AW-1:0]),
      .wr_data (x_val),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign ram_rd_addr = scan_ff[AW-1:0];
   assign scan_prod   = SUM_W'(ram_rd_data) * SUM_W'(kept_ff);

   // Variance numerator and divisor.
   assign num_val = (mul_acc_ff > sqr_ff) ? (mul_acc_ff - sqr_ff) : '0;
   assign nn_val  = DW'(kept_ff) * DW'(kept_ff - CNT_W'(1));

   // Operands of the current division.
   always_comb begin
      unique case (job_ff)
         JOB_ABOVE: share_cnt = above_ff;
         JOB_UNDER: share_cnt = bin_ff[0];
         JOB_LOW:   share_cnt = bin_ff[1];
         JOB_MID:   share_cnt = bin_ff[2];
         JOB_HIGH:  share_cnt = bin_ff[3];
         default:   share_cnt = bin_ff[4];
      endcase
      unique case (job_ff)
         JOB_MEAN: begin
            job_dividend = DW'(sum_ff);
            job_divisor  = DW'(kept_ff);
         end
         JOB_VAR: begin
            job_dividend = DW'(num_val);
            job_divisor  = nn_val;
         end
         default: begin
            job_dividend = DW'(share_cnt) * DW'(PCT_SCALE);
            job_divisor  = DW'(kept_ff);
         end
      endcase
   end

   // One restoring division step.
   assign div_trial  = {div_rem_ff[DW-1:0], div_quo_ff[DW-1]};
   assign div_ge     = div_trial >= {1'b0, div_den_ff};
   assign div_rem_nx = div_ge ? (div_trial - {1'b0, div_den_ff}) : div_trial;
   assign div_quo_nx = {div_quo_ff[DW-2:0], div_ge};
   assign pct_idx    = 3'(job_ff) - 3'(JOB_ABOVE);

   // One square root step.
   assign sq_trial = {1'b0, sq_root_ff} + {1'b0, sq_bit_ff};
   assign sq_ge    = {1'b0, sq_v_ff} >= sq_trial;

   assign n_wide = (CNT_W+COUNT_OUT_W)'(kept_ff);

   // Sequencer and next-state logic.
   always_comb begin
      state_in      = state_ff;
      kept_in       = kept_ff;
      sum_in        = sum_ff;
      sq_in         = sq_ff;
      bin_in        = bin_ff;
      ovf_in        = ovf_ff;
      scan_in       = scan_ff;
      rd_pend_in    = 1'b0;
      above_in      = above_ff;
      sqr_in        = sqr_ff;
      step_in       = step_ff;
      mul_acc_in    = mul_acc_ff;
      mul_cand_in   = mul_cand_ff;
      mul_ier_in    = mul_ier_ff;
      job_in        = job_ff;
      div_busy_in   = div_busy_ff;
      div_rem_in    = div_rem_ff;
      div_quo_in    = div_quo_ff;
      div_den_in    = div_den_ff;
      mean_in       = mean_ff;
      var_in        = var_ff;
      pct_in        = pct_ff;
      sq_v_in       = sq_v_ff;
      sq_root_in    = sq_root_ff;
      sq_bit_in     = sq_bit_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_ready;
      rsp_count_in  = rsp_count_ff;
      rsp_mean_in   = rsp_mean_ff;
      rsp_sd_in     = rsp_sd_ff;
      rsp_pct_in    = rsp_pct_ff;
      rsp_status_in = rsp_status_ff;
      ram_wr_en     = 1'b0;

      unique case (state_ff)
         // Take samples; the last one starts the final pass.
         S_COLLECT: begin
            if (req_valid) begin
               if (kept_ff < CNT_W'(MAX_SAMPLES)) begin
                  ram_wr_en = 1'b1;
                  kept_in   = kept_ff + CNT_W'(1);
                  sum_in    = sum_ff + SUM_W'(x_val);
                  sq_in     = sq_ff + SQ_W'(x_sq);
                  for (int b = 0; b < NUM_BINS; b++) begin
                     if (bin_hit[b]) begin
                        bin_in[b] = bin_ff[b] + CNT_W'(1);
                     end
                  end
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_last_sample) begin
                  state_in = S_SCAN;
                  scan_in  = '0;
                  above_in = '0;
               end
            end
         end
         // Read every stored sample back and count those above the mean.
         S_SCAN: begin
            sqr_in = NUM_W'(sum_ff) * NUM_W'(sum_ff);
            if (scan_ff != kept_ff) begin
               scan_in    = scan_ff + CNT_W'(1);
               rd_pend_in = 1'b1;
            end
            if (rd_pend_ff && (scan_prod > sum_ff)) begin
               above_in = above_ff + CNT_W'(1);
            end
            if ((scan_ff == kept_ff) && !rd_pend_ff) begin
               state_in    = S_MUL;
               step_in     = '0;
               mul_acc_in  = '0;
               mul_cand_in = NUM_W'(sq_ff);
               mul_ier_in  = kept_ff;
            end
         end
         // n times the square sum, one multiplier bit a cycle.
         S_MUL: begin
            if (mul_ier_ff[0]) begin
               mul_acc_in = mul_acc_ff + mul_cand_ff;
            end
            mul_cand_in = mul_cand_ff << 1;
            mul_ier_in  = mul_ier_ff >> 1;
            step_in     = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(CNT_W - 1)) begin
               state_in    = S_DIV;
               job_in      = JOB_MEAN;
               div_busy_in = 1'b0;
            end
         end
         // Shared divider: load a job, then one quotient bit a cycle.
         S_DIV: begin
            if (!div_busy_ff) begin
               div_busy_in = 1'b1;
               div_rem_in  = '0;
               div_quo_in  = job_dividend;
               div_den_in  = job_divisor;
               step_in     = '0;
            end else begin
               div_rem_in = div_rem_nx;
               div_quo_in = div_quo_nx;
               step_in    = step_ff + STEP_W'(1);
               if (step_ff == STEP_W'(DW - 1)) begin
                  div_busy_in = 1'b0;
                  unique case (job_ff)
                     JOB_MEAN: mean_in = div_quo_nx[VALUE_W-1:0];
                     JOB_VAR:  var_in  = div_quo_nx;
                     default:  pct_in[pct_idx] = div_quo_nx[PCT_W-1:0];
                  endcase
                  if (job_ff == JOB_TOP) begin
                     state_in   = S_SQRT;
                     sq_v_in    = (job_ff == JOB_VAR) ? div_quo_nx : var_ff;
                     sq_root_in = '0;
                     sq_bit_in  = DW'(1) << (DW - 2);
                     step_in    = '0;
                  end else begin
                     job_in = job_type'(3'(job_ff) + 3'd1);
                  end
               end
            end
         end
         // Floored square root, two radicand bits a cycle.
         S_SQRT: begin
            if (sq_ge) begin
               sq_v_in    = sq_v_ff - sq_trial[DW-1:0];
               sq_root_in = (sq_root_ff >> 1) + sq_bit_ff;
            end else begin
               sq_root_in = sq_root_ff >> 1;
            end
            sq_bit_in = sq_bit_ff >> 2;
            step_in   = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(RT_W - 1)) begin
               state_in = S_LOAD;
            end
         end
         // Hand the result to the output register once it is free.
         S_LOAD: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_count_in = n_wide[COUNT_OUT_W-1:0];
               rsp_mean_in  = mean_ff;
               rsp_sd_in    = (kept_ff >= CNT_W'(2)) ? sq_root_ff[VALUE_W-1:0] : '0;
               rsp_pct_in   = pct_ff;
               priority if (ovf_ff) begin
                  rsp_status_in = STATUS_OVERFLOW;
               end else if (kept_ff < CNT_W'(2)) begin
                  rsp_status_in = STATUS_SINGLE;
               end else begin
                  rsp_status_in = STATUS_OK;
               end
               state_in = S_COLLECT;
               kept_in  = '0;
               sum_in   = '0;
               sq_in    = '0;
               ovf_in   = 1'b0;
               for (int b = 0; b < NUM_BINS; b++) begin
                  bin_in[b] = '0;
               end
            end
         end
         default: begin
            state_in = S_COLLECT;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_COLLECT;
         kept_ff      <= '0;
         sum_ff       <= '0;
         sq_ff        <= '0;
         ovf_ff       <= 1'b0;
         rd_pend_ff   <= 1'b0;
         div_busy_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int b = 0; b < NUM_BINS; b++) begin
            bin_ff[b] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         kept_ff      <= kept_in;
         sum_ff       <= sum_in;
         sq_ff        <= sq_in;
         ovf_ff       <= ovf_in;
         rd_pend_ff   <= rd_pend_in;
         div_busy_ff  <= div_busy_in;
         rsp_valid_ff <= rsp_valid_in;
         bin_ff       <= bin_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      scan_ff       <= scan_in;
      above_ff      <= above_in;
      sqr_ff        <= sqr_in;
      step_ff       <= step_in;
      mul_acc_ff    <= mul_acc_in;
      mul_cand_ff   <= mul_cand_in;
      mul_ier_ff    <= mul_ier_in;
      job_ff        <= job_in;
      div_rem_ff    <= div_rem_in;
      div_quo_ff    <= div_quo_in;
      div_den_ff    <= div_den_in;
      mean_ff       <= mean_in;
      var_ff        <= var_in;
      pct_ff        <= pct_in;
      sq_v_ff       <= sq_v_in;
      sq_root_ff    <= sq_root_in;
      sq_bit_ff     <= sq_bit_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_mean_ff   <= rsp_mean_in;
      rsp_sd_ff     <= rsp_sd_in;
      rsp_pct_ff    <= rsp_pct_in;
      rsp_status_ff <= rsp_status_in;
   end

   // Result ports.
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_sample_count   = rsp_count_ff;
   assign rsp_mean_value     = rsp_mean_ff;
   assign rsp_std_dev        = rsp_sd_ff;
   assign rsp_pct_above_mean = rsp_pct_ff[0];
   assign rsp_pct_bin_under  = rsp_pct_ff[1];
   assign rsp_pct_bin_low    = rsp_pct_ff[2];
   assign rsp_pct_bin_mid    = rsp_pct_ff[3];
   assign rsp_pct_bin_high   = rsp_pct_ff[4];
   assign rsp_pct_bin_top    = rsp_pct_ff[5];
   assign rsp_status         = rsp_status_ff;

   // The store never holds more than its capacity.
   `SSB_ASSERT_IMPL(a_kept_bound, clock, reset, 1'b1, kept_ff <= CNT_W'(MAX_SAMPLES), "kept count beyond capacity")
   // A last sample always leads into the scan with a non-empty set.
   `SSB_ASSERT_NEXT(a_last_scan, clock, reset, req_valid && req_ready && req_last_sample, (state_ff == S_SCAN) && (kept_ff != '0), "last sample did not start scan")
   // Read data is only expected during the scan pass.
   `SSB_ASSERT_IMPL(a_read_in_scan, clock, reset, rd_pend_ff, state_ff == S_SCAN, "store read outside scan")
   // A pending result is not overwritten by the next one.
   `SSB_ASSERT_NEXT(a_no_overwrite, clock, reset, (state_ff == S_LOAD) && rsp_valid_ff && !rsp_ready, (state_ff == S_LOAD) && $stable(rsp_mean_ff) && $stable(rsp_status_ff), "result overwritten")

endmodule
